// ===== rtl/dhs_pkg.sv =====
// ============================================================================
// dhs_pkg
// Shared types and character constants for the decimal/hex string parser.
// ============================================================================
package dhs_pkg;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_LX  = 8'h78;
    localparam logic [7:0] CH_UX  = 8'h58;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF  = 8'h66;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;

    localparam logic [7:0] LETTER_BIAS = 8'd10;
    localparam logic [1:0] CPOS_MAX    = 2'd2;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic       is_nul;
        logic       is_x;
        logic       is_zero;
        logic       dec_ok;
        logic       hex_ok;
        logic [3:0] dig;
    } class_t;

endpackage

// ===== rtl/dhs_front.sv =====
// ============================================================================
// dhs_front
// Input side: classifies each character and pushes it into the queue.
// ============================================================================
module dhs_front
    import dhs_pkg::*;
(
    input  logic       in_valid,
    input  logic [7:0] ch,
    input  logic       q_full,
    output logic       in_stall,
    output logic       push,
    output class_t     entry
);

    logic       is_dec;
    logic       is_low;
    logic       is_up;
    logic [7:0] diff;

    assign is_dec = (ch >= CH_0) && (ch <= CH_9);
    assign is_low = (ch >= CH_LA) && (ch <= CH_LF);
    assign is_up  = (ch >= CH_UA) && (ch <= CH_UF);

    always_comb
    begin
        priority if (is_low)
        begin
            diff = ch - CH_LA + LETTER_BIAS;
        end
        else if (is_up)
        begin
            diff = ch - CH_UA + LETTER_BIAS;
        end
        else
        begin
            diff = ch - CH_0;
        end
    end

    assign entry.is_nul  = (ch == CH_NUL);
    assign entry.is_x    = (ch == CH_LX) || (ch == CH_UX);
    assign entry.is_zero = (ch == CH_0);
    assign entry.dec_ok  = is_dec;
    assign entry.hex_ok  = is_dec || is_low || is_up;
    assign entry.dig     = diff[3:0];

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

endmodule

// ===== rtl/dhs_queue.sv =====
// ============================================================================
// dhs_queue
// Short FIFO of classified characters between front and back.
// ============================================================================
module dhs_queue
    import dhs_pkg::*;
#(
    parameter int DEPTH = Q_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  class_t wr_entry,
    input  logic   pop,
    output logic   q_full,
    output logic   q_valid,
    output class_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    class_t          mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");
`endif

endmodule

// ===== rtl/dhs_back.sv =====
// ============================================================================
// dhs_back
// Execution side: accumulates digits, tracks prefix and errors, and holds
// the result register for the output channel.
// ============================================================================
module dhs_back
    import dhs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  class_t      head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [63:0] number
);

    logic [63:0] accum_reg, accum_next;
    logic        hex_reg, hex_next;
    logic [1:0]  cpos_reg, cpos_next;
    logic        fzero_reg, fzero_next;
    logic        need_reg, need_next;
    logic        failed_reg, failed_next;
    logic        out_valid_reg, out_valid_next;
    logic        ok_reg, ok_next;
    logic [63:0] number_reg, number_next;

    logic [67:0] prod;
    logic        ovf;
    logic        dig_ok;
    logic        good;

    always_comb
    begin
        if (hex_reg)
        begin
            prod = {accum_reg, 4'b0000} + {64'd0, head.dig};
        end
        else
        begin
            prod = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                 + {64'd0, head.dig};
        end
    end

    assign ovf    = |prod[67:64];
    assign dig_ok = hex_reg ? head.hex_ok : head.dec_ok;
    assign good   = !failed_reg && !need_reg;
    assign pop    = q_valid && (!head.is_nul || !out_valid_reg || !out_stall);

    always_comb
    begin
        accum_next     = accum_reg;
        hex_next       = hex_reg;
        cpos_next      = cpos_reg;
        fzero_next     = fzero_reg;
        need_next      = need_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        number_next    = number_reg;
        if (pop)
        begin
            if (head.is_nul)
            begin
                out_valid_next = 1'b1;
                ok_next        = good;
                number_next    = good ? accum_reg : 64'd0;
                accum_next     = '0;
                hex_next       = 1'b0;
                cpos_next      = '0;
                fzero_next     = 1'b0;
                need_next      = 1'b1;
                failed_next    = 1'b0;
            end
            else
            begin
                if (cpos_reg != CPOS_MAX)
                begin
                    cpos_next = cpos_reg + 1'b1;
                end
                if (!failed_reg)
                begin
                    priority if ((cpos_reg == 2'd1) && fzero_reg && !hex_reg
                                 && head.is_x)
                    begin
                        hex_next   = 1'b1;
                        need_next  = 1'b1;
                        accum_next = '0;
                    end
                    else if (!dig_ok || ovf)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        accum_next = prod[63:0];
                        need_next  = 1'b0;
                        if ((cpos_reg == 2'd0) && head.is_zero)
                        begin
                            fzero_next = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg     <= '0;
            hex_reg       <= 1'b0;
            cpos_reg      <= '0;
            fzero_reg     <= 1'b0;
            need_reg      <= 1'b1;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg     <= accum_next;
            hex_reg       <= hex_next;
            cpos_reg      <= cpos_next;
            fzero_reg     <= fzero_next;
            need_reg      <= need_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        number_reg <= number_next;
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign number    = number_reg;

`ifndef SYNTHESIS
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.is_nul) |=> (need_reg && !failed_reg && !hex_reg
                                  && (cpos_reg == 2'd0) && (accum_reg == 64'd0)))
        else $error("state not restarted after terminator");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !ok_reg) |-> (number_reg == 64'd0))
        else $error("failed result carries a value");
    a_hex_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        hex_reg |-> (fzero_reg && (cpos_reg != 2'd0)))
        else $error("hex mode without leading zero");
    a_cpos_sat: assert property (@(posedge clk) disable iff (!rst_n)
        cpos_reg != 2'd3)
        else $error("character position past saturation");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(number_reg)))
        else $error("held result overwritten");
`endif

endmodule

// ===== rtl/decimal_hex_string_to_u64_core.sv =====
// ============================================================================
// decimal_hex_string_to_u64_core
// Streaming parser of a NUL-terminated string into an unsigned 64-bit value.
// ============================================================================
// Input channel (in_valid/in_stall, ch) carries one character per
// transaction. A leading 0x or 0X selects hexadecimal, otherwise decimal.
// Output channel (out_valid/out_stall, ok, number) carries one transaction
// per string, on the NUL terminator: ok = 1 with the value, or ok = 0 with
// number = 0 for an empty string, bare prefix, bad digit or overflow.
// Throughput: one character per cycle while no held result stops the queue,
// set by the combinational multiply-by-10/16, add and overflow check in the
// back end. Result path: an accepted terminator is written into the queue,
// then the back end executes it into the output register, raising out_valid.
// A queue of QUEUE_DEPTH entries sits between classifier and back end; a
// result held by out_stall blocks only the next terminator, other
// characters keep flowing until the queue fills and in_stall rises.
// Reset clears the queue and output valid and starts a new string.
// ============================================================================
module decimal_hex_string_to_u64_core
    import dhs_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        ok,
    output logic [63:0] number
);

    class_t wr_entry;
    class_t head;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    dhs_front u_front
    (
        .in_valid (in_valid),
        .ch       (ch),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (push),
        .entry    (wr_entry)
    );

    dhs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .head     (head)
    );

    dhs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .number    (number)
    );

endmodule

// ===== tb/decimal_hex_string_to_u64_core_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// decimal_hex_string_to_u64_core_tb
// Self-checking bench for the decimal/hex string parser. A driver feeds
// NUL-terminated strings one character per transaction, with random gaps. A
// monitor applies random output stall. It tracks the parser state for every
// accepted character and checks each result against the predicted one.
// Stimulus is a short directed set of strings, followed by random strings:
// well-formed decimal and hex, values near the 64-bit limit, broken strings
// and byte noise.
// ============================================================================
module decimal_hex_string_to_u64_core_tb
    import dhs_pkg::*;
();

    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam logic [4:0]  BASE_DEC     = 5'd10;
    localparam logic [4:0]  BASE_HEX     = 5'd16;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
    } parse_result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  ch        = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        ok;
    logic [63:0] number;

    logic [7:0]    pending_chars[$];
    logic [7:0]    text[$];
    parse_result_t expected_results[$];
    parse_result_t want;

    // parser state as predicted
    logic [63:0] p_acc;
    logic        p_hex;
    logic [1:0]  p_pos;
    logic        p_lead_zero;
    logic        p_need_digit;
    logic        p_failed;

    int unsigned cycle_count  = 0;
    int unsigned err_count    = 0;
    int unsigned send_gap     = 0;
    int unsigned send_calm    = 0;
    int unsigned stall_left   = 0;
    int unsigned stall_calm   = 0;
    int unsigned results_due  = 0;
    int unsigned results_seen = 0;
    bit          timed_out    = 1'b0;

    decimal_hex_string_to_u64_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .ch        (ch),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .ok        (ok),
        .number    (number)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // mostly short idles, a few long ones, and occasional idle-free runs
    function automatic int unsigned pick_idle(inout int unsigned calm);
        int unsigned r;
        if (calm != 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < BASE_DEC)
            return CH_0 + d;
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + d - LETTER_BIAS;
    endfunction

    task automatic clear_parser();
        p_acc        = '0;
        p_hex        = 1'b0;
        p_pos        = '0;
        p_lead_zero  = 1'b0;
        p_need_digit = 1'b1;
        p_failed     = 1'b0;
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [1:0]  pos_now;
        logic [3:0]  dig;
        logic        is_digit;
        logic [4:0]  base;
        logic [67:0] wide;
        pos_now = p_pos;
        if (c == CH_NUL)
        begin
            want.ok    = !p_failed && !p_need_digit;
            want.value = want.ok ? p_acc : 64'd0;
            expected_results.push_back(want);
            clear_parser();
            return;
        end
        if (p_pos < CPOS_MAX)
            p_pos++;
        if (p_failed)
            return;
        if (pos_now == 2'd1 && p_lead_zero && !p_hex && (c == CH_LX || c == CH_UX))
        begin
            p_hex        = 1'b1;
            p_need_digit = 1'b1;
            p_acc        = '0;
            return;
        end
        is_digit = 1'b1;
        dig      = '0;
        if (c >= CH_0 && c <= CH_9)
            dig = 4'(c - CH_0);
        else if (p_hex && c >= CH_LA && c <= CH_LF)
            dig = 4'(c - CH_LA + LETTER_BIAS);
        else if (p_hex && c >= CH_UA && c <= CH_UF)
            dig = 4'(c - CH_UA + LETTER_BIAS);
        else
            is_digit = 1'b0;
        if (!is_digit)
        begin
            p_failed = 1'b1;
            return;
        end
        base = p_hex ? BASE_HEX : BASE_DEC;
        wide = 68'(p_acc) * 68'(base) + 68'(dig);
        if (wide[67:64] != '0)
        begin
            p_failed = 1'b1;
            return;
        end
        p_acc        = wide[63:0];
        p_need_digit = 1'b0;
        if (pos_now == 2'd0 && c == CH_0)
            p_lead_zero = 1'b1;
    endtask

    task automatic commit_text();
        foreach (text[i])
            pending_chars.push_back(text[i]);
        pending_chars.push_back(CH_NUL);
        text.delete();
    endtask

    task automatic add_literal(input string s);
        foreach (s[i])
            text.push_back(s[i]);
        commit_text();
    endtask

    task automatic append_value(input logic [63:0] v, input bit hex);
        logic [7:0]  digits[$];
        logic [63:0] rest;
        logic [3:0]  d;
        rest = v;
        do
        begin
            if (hex)
            begin
                d    = rest[3:0];
                rest = rest >> 4;
            end
            else
            begin
                d    = 4'(rest % 10);
                rest = rest / 10;
            end
            digits.push_front(digit_char(d));
        end while (rest != 0);
        foreach (digits[i])
            text.push_back(digits[i]);
    endtask

    task automatic add_random_string();
        int unsigned kind;
        int unsigned spot;
        logic [63:0] v;
        bit          hex;
        kind = $urandom_range(0, 99);
        if (kind < 3)
        begin
            commit_text();
            return;
        end
        if (kind < 11)
        begin
            repeat ($urandom_range(1, 6))
                text.push_back(8'($urandom_range(1, 255)));
            commit_text();
            return;
        end
        hex = $urandom_range(0, 1);
        if (hex)
        begin
            text.push_back(CH_0);
            text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
                text.push_back(CH_0);
        end
        if (kind >= 14)
        begin
            v = {$urandom, $urandom};
            if ($urandom_range(0, 5) == 0)
                v = '1;
            else
                v = v >> $urandom_range(0, 63);
            append_value(v, hex);
            // one more digit pushes long values over the 64-bit edge
            if ($urandom_range(0, 5) == 0)
                text.push_back(digit_char(4'($urandom_range(0, hex ? 15 : 9))));
        end
        if (kind >= 88 && text.size() != 0)
        begin
            spot = $urandom_range(0, text.size() - 1);
            if (kind < 94)
                text[spot] = 8'($urandom_range(1, 255));
            else
                text.insert(spot, $urandom_range(0, 1) ? CH_LX : CH_UX);
        end
        commit_text();
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ch       <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_chars.size() != 0)
            begin
                ch       <= pending_chars.pop_front();
                in_valid <= 1'b1;
                send_gap = pick_idle(send_calm);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    task automatic note_error(input string what);
        err_count++;
        if (err_count <= 10)
            $display("[%0d] %s", cycle_count, what);
    endtask

    // monitor: tracks accepted characters, checks results, drives stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                parse_char(ch);
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    note_error($sformatf("unexpected transaction ok=%0b number=%h", ok, number));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (ok !== want.ok || number !== want.value)
                        note_error($sformatf("expected ok=%0b number=%h, got ok=%0b number=%h",
                                             want.ok, want.value, ok, number));
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_idle(stall_calm);
                if (stall_left != 0)
                begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        int unsigned directed_len;
        clear_parser();
        add_literal("");
        add_literal("0");
        add_literal("0x");
        add_literal("0X");
        add_literal("x");
        add_literal("00x");
        text.push_back(CH_9);
        text.push_back(8'hFF);
        commit_text();
        add_literal("0xaF");
        add_literal("12a");
        directed_len = pending_chars.size();
        while (pending_chars.size() < directed_len + RANDOM_ITEMS)
            add_random_string();
        foreach (pending_chars[i])
            if (pending_chars[i] == CH_NUL)
                results_due++;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (results_seen < results_due && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        timed_out = (cycle_count >= CYCLE_LIMIT);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            note_error($sformatf("%0d results never arrived", expected_results.size()));
        if (err_count == 0 && !timed_out)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dhs_pkg.sv
rtl/dhs_front.sv
rtl/dhs_queue.sv
rtl/dhs_back.sv
rtl/decimal_hex_string_to_u64_core.sv
tb/decimal_hex_string_to_u64_core_tb.sv
